// ===== hdl/svpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// svpwm_pkg
// shared types, constants and the sector decode for the svpwm compare block
// ----------------------------------------------------------------------------
package svpwm_pkg;

  // sqrt3 in q32, rounded per frac width where it is used
  localparam logic [63:0] SQRT3_Q32 = 64'd7439101574;

  localparam int TP_W  = 16;
  localparam int CMP_W = 15;

  typedef enum logic [2:0] {
    SEC_ZERO = 3'd0,
    SEC_1    = 3'd1,
    SEC_2    = 3'd2,
    SEC_3    = 3'd3,
    SEC_4    = 3'd4,
    SEC_5    = 3'd5,
    SEC_6    = 3'd6
  } sector_e;

  typedef struct packed {
    sector_e sector;
    logic    over;
    logic    dc_fault;
  } side_t;

  // sign-test code to sector
  function automatic sector_e sector_of(input logic [2:0] code);
    sector_e s;
    unique case (code)
      3'd1:    s = SEC_2;
      3'd2:    s = SEC_6;
      3'd3:    s = SEC_1;
      3'd4:    s = SEC_4;
      3'd5:    s = SEC_3;
      3'd6:    s = SEC_5;
      default: s = SEC_ZERO;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/svpwm_ifs.sv =====
// ----------------------------------------------------------------------------
// svpwm channel interfaces
// valid/ready channels for reference words and compare words
// ----------------------------------------------------------------------------
interface svpwm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] v_alpha;
  logic signed [15:0] v_beta;
  logic        [15:0] dc_link;

  modport source (output valid, v_alpha, v_beta, dc_link, input ready);
  modport sink   (input valid, v_alpha, v_beta, dc_link, output ready);
endinterface

interface svpwm_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] compare_a;
  logic [14:0] compare_b;
  logic [14:0] compare_c;
  logic [2:0]  sector_number;
  logic        overmodulated;
  logic        dc_fault;

  modport source (output valid, compare_a, compare_b, compare_c, sector_number,
                  overmodulated, dc_fault, input ready);
  modport sink   (input valid, compare_a, compare_b, compare_c, sector_number,
                  overmodulated, dc_fault, output ready);
endinterface

// ===== hdl/svpwm_front.sv =====
// ----------------------------------------------------------------------------
// svpwm_front
// sector classification, active-time numerators, overmodulation test and divisor, three stages
// ----------------------------------------------------------------------------
module svpwm_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [15:0]     v_alpha_i,
  input  logic signed [15:0]     v_beta_i,
  input  logic        [15:0]     dc_link_i,
  input  logic        [15:0]     tp_i,
  output logic                   valid_o,
  output logic [FRAC_BITS+17:0]  n1_o,
  output logic [FRAC_BITS+17:0]  n2_o,
  output logic [FRAC_BITS+18:0]  div_o,
  output svpwm_pkg::side_t       side_o
);
  import svpwm_pkg::*;

  localparam int NW = FRAC_BITS + 19;
  localparam int UW = FRAC_BITS + 18;
  localparam int BW = FRAC_BITS + 19;
  localparam int SW = FRAC_BITS + 2;
  localparam int PW = FRAC_BITS + 18;
  localparam logic [63:0] S3_L =
    (SQRT3_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  localparam logic signed [SW-1:0] S3 = $signed(S3_L[SW-1:0]);

  // stage 1
  logic               v1_q;
  logic signed [15:0] va1_q, vb1_q;
  logic [15:0]        vdc1_q;
  logic [30:0]        sqa1_q, sqb1_q;
  logic signed [PW-1:0] s3vb1_q;
  logic signed [31:0] sqa_w, sqb_w;
  logic signed [PW-1:0] s3vb_w;

  assign sqa_w  = v_alpha_i * v_alpha_i;
  assign sqb_w  = v_beta_i * v_beta_i;
  assign s3vb_w = S3 * v_beta_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      va1_q   <= v_alpha_i;
      vb1_q   <= v_beta_i;
      vdc1_q  <= dc_link_i;
      sqa1_q  <= sqa_w[30:0];
      sqb1_q  <= sqb_w[30:0];
      s3vb1_q <= s3vb_w;
    end
  end

  // stage 2: exact sqrt3 sign tests, numerators
  logic [32:0] sqa3, sqb_e;
  logic gt_p, lt_p, vbn, vbp, van, vap, g1, g2;
  sector_e sec2;
  logic signed [NW-1:0] va_e, va3f, s3e, nx, ny, nz, n1s, n2s;
  logic [UW-1:0] n1c, n2c;

  always_comb begin
    sqa3  = {2'b00, sqa1_q} + {1'b0, sqa1_q, 1'b0};
    sqb_e = {2'b00, sqb1_q};
    gt_p  = sqa3 > sqb_e;
    lt_p  = sqb_e > sqa3;
    vbn   = vb1_q[15];
    vbp   = !vb1_q[15] && (vb1_q != 16'sd0);
    van   = va1_q[15];
    vap   = !va1_q[15] && (va1_q != 16'sd0);
    g1    = vap ? (vbn || gt_p) : (van ? (vbn && lt_p) : vbn);
    g2    = van ? (vbn || gt_p) : (vap ? (vbn && lt_p) : vbn);
    sec2  = sector_of({g2, g1, vbp});

    va_e = NW'(va1_q);
    va3f = (va_e + (va_e <<< 1)) <<< FRAC_BITS;
    s3e  = NW'(s3vb1_q);
    nx   = s3e <<< 1;
    ny   = va3f + s3e;
    nz   = s3e - va3f;

    unique case (sec2)
      SEC_1:   begin n1s = -nz; n2s = nx;  end
      SEC_2:   begin n1s = nz;  n2s = ny;  end
      SEC_3:   begin n1s = nx;  n2s = -ny; end
      SEC_4:   begin n1s = -nx; n2s = nz;  end
      SEC_5:   begin n1s = -ny; n2s = -nz; end
      SEC_6:   begin n1s = ny;  n2s = -nx; end
      default: begin n1s = '0;  n2s = '0;  end
    endcase

    // negative on a sector edge, or no dc link: no active time
    n1c = (n1s[NW-1] || vdc1_q == 16'd0) ? '0 : n1s[UW-1:0];
    n2c = (n2s[NW-1] || vdc1_q == 16'd0) ? '0 : n2s[UW-1:0];
  end

  logic          v2_q;
  logic [UW-1:0] n1_2_q, n2_2_q;
  logic [15:0]   vdc2_q;
  sector_e       sec2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n1_2_q <= n1c;
      n2_2_q <= n2c;
      vdc2_q <= vdc1_q;
      sec2_q <= sec2;
    end
  end

  // stage 3: overmodulation test and divisor
  logic [BW-1:0] sum, lim, div_d;
  logic          over;

  always_comb begin
    sum   = BW'(n1_2_q) + BW'(n2_2_q);
    lim   = BW'({vdc2_q, 1'b0}) << FRAC_BITS;
    over  = (tp_i != 16'd0) && (sum > lim);
    div_d = over ? sum : ((vdc2_q == 16'd0) ? BW'(1) : lim);
  end

  logic v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n1_o            <= n1_2_q;
      n2_o            <= n2_2_q;
      div_o           <= div_d;
      side_o.sector   <= sec2_q;
      side_o.over     <= over;
      side_o.dc_fault <= (vdc2_q == 16'd0);
    end
  end

  assign valid_o = v3_q;

endmodule

// ===== hdl/svpwm_fifo.sv =====
// ----------------------------------------------------------------------------
// svpwm_fifo
// short register queue between front and back, depth a power of two
// ----------------------------------------------------------------------------
module svpwm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic             full_o
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [0:DEPTH-1];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

endmodule

// ===== hdl/svpwm_back.sv =====
// ----------------------------------------------------------------------------
// svpwm_back
// active-time multiply, pipelined restoring dividers and compare values
// ----------------------------------------------------------------------------
module svpwm_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [FRAC_BITS+17:0] n1_i,
  input  logic [FRAC_BITS+17:0] n2_i,
  input  logic [FRAC_BITS+18:0] div_i,
  input  svpwm_pkg::side_t      side_i,
  input  logic [15:0]           tp_i,
  output logic                  valid_o,
  output logic [14:0]           compare_a_o,
  output logic [14:0]           compare_b_o,
  output logic [14:0]           compare_c_o,
  output svpwm_pkg::side_t      side_o
);
  import svpwm_pkg::*;

  localparam int UW  = FRAC_BITS + 18;
  localparam int BW  = FRAC_BITS + 19;
  localparam int RW  = BW + 1;
  localparam int QW  = FRAC_BITS + 16;
  localparam int LO  = UW / 2;
  localparam int HW  = UW - LO;
  localparam int PRW = FRAC_BITS + 34;
  localparam int TW  = FRAC_BITS + 19;

  // k0: partial products of n * tp
  logic              v0_q;
  logic [LO+15:0]    p1l_q, p2l_q;
  logic [HW+15:0]    p1h_q, p2h_q;
  logic [BW-1:0]     d0_q;
  side_t             s0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1l_q <= (LO+16)'(n1_i[LO-1:0]) * (LO+16)'(tp_i);
      p2l_q <= (LO+16)'(n2_i[LO-1:0]) * (LO+16)'(tp_i);
      p1h_q <= (HW+16)'(n1_i[UW-1:LO]) * (HW+16)'(tp_i);
      p2h_q <= (HW+16)'(n2_i[UW-1:LO]) * (HW+16)'(tp_i);
      d0_q  <= div_i;
      s0_q  <= side_i;
    end
  end

  // divider stage arrays, index 0 is the loaded stage
  logic          v_q  [0:QW];
  logic [RW-1:0] r1_q [0:QW];
  logic [RW-1:0] r2_q [0:QW];
  logic [15:0]   l1_q [0:QW];
  logic [15:0]   l2_q [0:QW];
  logic [QW-1:0] q1_q [0:QW];
  logic [QW-1:0] q2_q [0:QW];
  logic [BW-1:0] d_q  [0:QW];
  side_t         s_q  [0:QW];

  logic [PRW-1:0] prod1, prod2;

  // dividend is prod << frac; top part loads the remainder
  assign prod1 = (PRW'(p1h_q) << LO) + PRW'(p1l_q);
  assign prod2 = (PRW'(p2h_q) << LO) + PRW'(p2l_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_q[0] <= RW'(prod1[PRW-1:16]);
      r2_q[0] <= RW'(prod2[PRW-1:16]);
      l1_q[0] <= prod1[15:0];
      l2_q[0] <= prod2[15:0];
      q1_q[0] <= '0;
      q2_q[0] <= '0;
      d_q[0]  <= d0_q;
      s_q[0]  <= s0_q;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    logic [RW-1:0] t1, t2;
    logic          ge1, ge2;

    assign t1  = {r1_q[i][RW-2:0], l1_q[i][15]};
    assign t2  = {r2_q[i][RW-2:0], l2_q[i][15]};
    assign ge1 = t1 >= {1'b0, d_q[i]};
    assign ge2 = t2 >= {1'b0, d_q[i]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r1_q[i+1] <= ge1 ? (t1 - {1'b0, d_q[i]}) : t1;
        r2_q[i+1] <= ge2 ? (t2 - {1'b0, d_q[i]}) : t2;
        l1_q[i+1] <= l1_q[i] << 1;
        l2_q[i+1] <= l2_q[i] << 1;
        q1_q[i+1] <= {q1_q[i][QW-2:0], ge1};
        q2_q[i+1] <= {q2_q[i][QW-2:0], ge2};
        d_q[i+1]  <= d_q[i];
        s_q[i+1]  <= s_q[i];
      end
    end
  end

  // round half up
  logic          vr_q;
  logic [QW:0]   t1r_q, t2r_q;
  side_t         sr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= 1'b0;
    end else if (en_i) begin
      vr_q <= v_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1r_q <= (QW+1)'(q1_q[QW]) +
               (QW+1)'((r1_q[QW] << 1) >= {1'b0, d_q[QW]});
      t2r_q <= (QW+1)'(q2_q[QW]) +
               (QW+1)'((r2_q[QW] << 1) >= {1'b0, d_q[QW]});
      sr_q  <= s_q[QW];
    end
  end

  // phase times times four, q(frac)
  logic                 vt_q;
  logic signed [TW-1:0] ta4_q, tb4_q, tc4_q;
  side_t                st_q;
  logic signed [TW-1:0] pe, t1e, t2e;

  always_comb begin
    pe  = TW'({tp_i, {FRAC_BITS{1'b0}}});
    t1e = TW'(t1r_q);
    t2e = sr_q.over ? (pe - t1e) : TW'(t2r_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vt_q <= 1'b0;
    end else if (en_i) begin
      vt_q <= vr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ta4_q <= pe - t1e - t2e;
      tb4_q <= pe + t1e - t2e;
      tc4_q <= pe + t1e + t2e;
      st_q  <= sr_q;
    end
  end

  function automatic logic [14:0] to_cnt(input logic signed [TW-1:0] t4,
                                         input logic [14:0] half);
    logic signed [TW-1:0] s;
    logic [16:0]          c;
    logic [14:0]          res;
    s = t4 + (TW'(1) <<< (FRAC_BITS + 1));
    c = s[TW-1:FRAC_BITS+2];
    if (t4 < 0)                  res = '0;
    else if (c > {2'b00, half})  res = half;
    else                         res = c[14:0];
    return res;
  endfunction

  logic [14:0] ca, cb, cc, xa, xb, xc, half;

  always_comb begin
    half = tp_i[15:1];
    xa   = to_cnt(ta4_q, half);
    xb   = to_cnt(tb4_q, half);
    xc   = to_cnt(tc4_q, half);
    unique case (st_q.sector)
      SEC_2:   begin ca = xb; cb = xa; cc = xc; end
      SEC_3:   begin ca = xc; cb = xa; cc = xb; end
      SEC_4:   begin ca = xc; cb = xb; cc = xa; end
      SEC_5:   begin ca = xb; cb = xc; cc = xa; end
      SEC_6:   begin ca = xa; cb = xc; cc = xb; end
      default: begin ca = xa; cb = xb; cc = xc; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= vt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      compare_a_o <= ca;
      compare_b_o <= cb;
      compare_c_o <= cc;
      side_o      <= st_q;
    end
  end

endmodule

// ===== hdl/svpwm_two_level_compare_top.sv =====
// ----------------------------------------------------------------------------
// svpwm_two_level_compare_top
// two-level space vector pwm compare generator
// ----------------------------------------------------------------------------
// Takes one alpha/beta reference and dc link word per cycle and returns one
// compare word per reference, in order. Throughput is one word per clock while nothing stalls.
// The accept edge loads the first of FRAC_BITS + 25 register stages, and output
// valid rises as the word is loaded into the last of them.
// The stages are three front stages, one queue slot, two multiply stages,
// FRAC_BITS + 16 one-bit restoring divider stages, then rounding, phase time
// and compare stages. The divider depth sets the latency. carrier_period is
// written through carrier_period_we_i / carrier_period_i and must only change
// while the block is empty. dc link of zero sets dc_fault and gives zero
// active times; the compare values are clamped to 0 .. carrier_period/2.
// ----------------------------------------------------------------------------
module svpwm_two_level_compare_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         carrier_period_we_i,
  input  logic [15:0]  carrier_period_i,
  svpwm_in_if.sink     in_i,
  svpwm_out_if.source  out_o
);
  import svpwm_pkg::*;

  localparam int UW = FRAC_BITS + 18;
  localparam int BW = FRAC_BITS + 19;
  localparam int FW = 2 * UW + BW + $bits(side_t);

  // carrier period register
  logic [15:0] tp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tp_q <= 16'd10000;
    end else if (carrier_period_we_i) begin
      tp_q <= carrier_period_i;
    end
  end

  // front: stalls only when its last stage holds a word and the queue is full
  logic          f_valid, f_en, q_full, q_empty, q_pop, b_en;
  logic [UW-1:0] f_n1, f_n2, b_n1, b_n2;
  logic [BW-1:0] f_div, b_div;
  side_t         f_side, b_side, o_side;

  assign f_en       = !(f_valid && q_full);
  assign in_i.ready = f_en;

  svpwm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (f_en),
    .valid_i   (in_i.valid),
    .v_alpha_i (in_i.v_alpha),
    .v_beta_i  (in_i.v_beta),
    .dc_link_i (in_i.dc_link),
    .tp_i      (tp_q),
    .valid_o   (f_valid),
    .n1_o      (f_n1),
    .n2_o      (f_n2),
    .div_o     (f_div),
    .side_o    (f_side)
  );

  // queue between classification and the divider pipeline
  logic [FW-1:0] q_out;

  svpwm_fifo #(.WIDTH(FW), .DEPTH(2)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid && f_en),
    .data_i  ({f_n1, f_n2, f_div, f_side}),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  assign {b_n1, b_n2, b_div, b_side} = q_out;

  // back pipeline moves whenever the output register can take a word
  assign b_en  = !out_o.valid || out_o.ready;
  assign q_pop = b_en && !q_empty;

  svpwm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (b_en),
    .valid_i     (q_pop),
    .n1_i        (b_n1),
    .n2_i        (b_n2),
    .div_i       (b_div),
    .side_i      (b_side),
    .tp_i        (tp_q),
    .valid_o     (out_o.valid),
    .compare_a_o (out_o.compare_a),
    .compare_b_o (out_o.compare_b),
    .compare_c_o (out_o.compare_c),
    .side_o      (o_side)
  );

  assign out_o.sector_number = o_side.sector;
  assign out_o.overmodulated = o_side.over;
  assign out_o.dc_fault      = o_side.dc_fault;

endmodule

// ===== hdl/svpwm_chk.sv =====
// ----------------------------------------------------------------------------
// svpwm_chk
// port-level checks for the svpwm compare block, bound to the top level
// ----------------------------------------------------------------------------
module svpwm_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [14:0] compare_a_i,
  input logic [2:0]  sector_number_i,
  input logic        overmodulated_i,
  input logic        dc_fault_i
);

  // stalled word stays
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(compare_a_i))
    else $error("output word changed while stalled");

  // no overmodulation flag without dc link
  a_dc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && dc_fault_i |-> !overmodulated_i)
    else $error("overmodulation flagged with dc fault");

  // zero vector is never flagged as overmodulated
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && sector_number_i == 3'd0 |-> !overmodulated_i)
    else $error("overmodulation flagged on zero vector");

endmodule

bind svpwm_two_level_compare_top svpwm_chk u_svpwm_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .compare_a_i     (out_o.compare_a),
  .sector_number_i (out_o.sector_number),
  .overmodulated_i (out_o.overmodulated),
  .dc_fault_i      (out_o.dc_fault)
);

// ===== tb/svpwm_two_level_compare_top_test.sv =====
// ----------------------------------------------------------------------------
// svpwm_two_level_compare_top_test
// self-checking bench for the two-level svpwm compare generator
// ----------------------------------------------------------------------------
// Reference words go in through a valid/ready channel, and compare words are
// checked in order against a bit-exact fixed point predictor of sector
// selection, active times, overmodulation scaling and compare rounding. The
// carrier period is stepped through several values between phases, and both
// sides of the block idle at random, including one long output stall.
// ----------------------------------------------------------------------------
module svpwm_two_level_compare_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import svpwm_pkg::*;

  localparam int  FRAC     = 16;
  localparam int  LATENCY  = FRAC + 26;
  localparam int  WD_LIMIT = 20000;
  localparam int  HOLD_LEN = 400;
  // sqrt3 in q16, round to nearest
  localparam longint SQRT3_Q16 = 64'd113512;

  typedef struct packed {
    logic [14:0] cmp_a;
    logic [14:0] cmp_b;
    logic [14:0] cmp_c;
    logic [2:0]  sector;
    logic        over;
    logic        fault;
  } cmp_word_t;

  // --------------------------------------------------------------------------
  // compare word predictor and in-order store of expected words
  // --------------------------------------------------------------------------
  class svpwm_scoreboard;
    cmp_word_t pending_q[$];
    int        mismatches;
    int        words_checked;

    function new();
      mismatches    = 0;
      words_checked = 0;
    endfunction

    // exact test of sqrt3 * u > v
    function bit root3_above(longint u, longint v);
      if (u > 0) return (v < 0) || (3 * u * u > v * v);
      if (u == 0) return v < 0;
      return (v < 0) && (v * v > 3 * u * u);
    endfunction

    // round(num * 2^sh / den), halves up
    function longint unsigned scaled_quot(longint unsigned num, longint unsigned den,
                                          int sh);
      longint unsigned q, r;
      q = num / den;
      r = num % den;
      for (int i = 0; i < sh; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q = q | 1;
        end
      end
      if (r >= den - r) q++;
      return q;
    endfunction

    function longint unsigned to_counts(longint t4, longint unsigned lim);
      longint unsigned c;
      if (t4 < 0) return 0;
      c = (longint'(t4) + (longint'(1) << (FRAC + 1))) >> (FRAC + 2);
      return (c > lim) ? lim : c;
    endfunction

    function cmp_word_t predict_compare(logic signed [15:0] va_in,
                                        logic signed [15:0] vb_in,
                                        logic [15:0] vdc_in, logic [15:0] tp_in);
      longint va, vb, nx, ny, nz, n1, n2, ta4, tb4, tc4;
      longint unsigned vdc, tp, p, t1, t2, half, ca, cb, cc;
      logic [2:0] code;
      sector_e sec;
      cmp_word_t w;
      va   = va_in;
      vb   = vb_in;
      vdc  = vdc_in;
      tp   = tp_in;
      p    = tp << FRAC;
      half = tp >> 1;
      n1   = 0;
      n2   = 0;
      w.over = 1'b0;
      code = {root3_above(-va, vb), root3_above(va, vb), vb > 0};
      case (code)
        3'd1:    sec = SEC_2;
        3'd2:    sec = SEC_6;
        3'd3:    sec = SEC_1;
        3'd4:    sec = SEC_4;
        3'd5:    sec = SEC_3;
        3'd6:    sec = SEC_5;
        default: sec = SEC_ZERO;
      endcase
      nx = 2 * SQRT3_Q16 * vb;
      ny = 3 * va * (longint'(1) << FRAC) + SQRT3_Q16 * vb;
      nz = -3 * va * (longint'(1) << FRAC) + SQRT3_Q16 * vb;
      case (sec)
        SEC_1: begin n1 = -nz; n2 = nx;  end
        SEC_2: begin n1 = nz;  n2 = ny;  end
        SEC_3: begin n1 = nx;  n2 = -ny; end
        SEC_4: begin n1 = -nx; n2 = nz;  end
        SEC_5: begin n1 = -ny; n2 = -nz; end
        SEC_6: begin n1 = ny;  n2 = -nx; end
        default: ;
      endcase
      // rounding of sqrt3 can leave a slightly negative time on an edge
      if (n1 < 0) n1 = 0;
      if (n2 < 0) n2 = 0;
      if (vdc == 0) begin
        n1 = 0;
        n2 = 0;
      end
      if (tp > 0 && longint'(n1 + n2) > longint'((2 * vdc) << FRAC)) begin
        w.over = 1'b1;
        t1 = scaled_quot(n1 * tp, n1 + n2, FRAC);
        if (t1 > p) t1 = p;
        t2 = p - t1;
      end else if (vdc > 0) begin
        t1 = scaled_quot(n1 * tp, 2 * vdc, 0);
        t2 = scaled_quot(n2 * tp, 2 * vdc, 0);
      end else begin
        t1 = 0;
        t2 = 0;
      end
      ta4 = longint'(p) - longint'(t1) - longint'(t2);
      tb4 = ta4 + 2 * longint'(t1);
      tc4 = tb4 + 2 * longint'(t2);
      ca = to_counts(ta4, half);
      cb = to_counts(tb4, half);
      cc = to_counts(tc4, half);
      case (sec)
        SEC_2:   w.cmp_a = cb[14:0];
        SEC_3,
        SEC_4:   w.cmp_a = cc[14:0];
        SEC_5:   w.cmp_a = cb[14:0];
        default: w.cmp_a = ca[14:0];
      endcase
      case (sec)
        SEC_2,
        SEC_3:   w.cmp_b = ca[14:0];
        SEC_4:   w.cmp_b = cb[14:0];
        SEC_5,
        SEC_6:   w.cmp_b = cc[14:0];
        default: w.cmp_b = cb[14:0];
      endcase
      case (sec)
        SEC_3,
        SEC_6:   w.cmp_c = cb[14:0];
        SEC_4,
        SEC_5:   w.cmp_c = ca[14:0];
        default: w.cmp_c = cc[14:0];
      endcase
      w.sector = sec;
      w.fault  = (vdc == 0);
      return w;
    endfunction

    function void note_reference(logic signed [15:0] va, logic signed [15:0] vb,
                                 logic [15:0] vdc, logic [15:0] tp);
      pending_q.push_back(predict_compare(va, vb, vdc, tp));
    endfunction

    function void check_compare(cmp_word_t got);
      cmp_word_t exp_w;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected compare word %p", $realtime, got);
        return;
      end
      exp_w = pending_q.pop_front();
      words_checked++;
      if (got !== exp_w) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] compare word %0d mismatch", $realtime, words_checked);
          $display("  a %0d/%0d b %0d/%0d c %0d/%0d sector %0d/%0d over %0b/%0b fault %0b/%0b",
                   exp_w.cmp_a, got.cmp_a, exp_w.cmp_b, got.cmp_b, exp_w.cmp_c,
                   got.cmp_c, exp_w.sector, got.sector, exp_w.over, got.over,
                   exp_w.fault, got.fault);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and the block
  // --------------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        carrier_period_we_i = 1'b0;
  logic [15:0] carrier_period_i = 16'd0;

  always #1 clk_i = ~clk_i;

  svpwm_in_if  ref_ch ();
  svpwm_out_if cmp_ch ();

  svpwm_two_level_compare_top #(.FRAC_BITS(FRAC)) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .carrier_period_we_i (carrier_period_we_i),
    .carrier_period_i    (carrier_period_i),
    .in_i                (ref_ch.sink),
    .out_o               (cmp_ch.source)
  );

  svpwm_scoreboard sb = new();

  logic [15:0] period_now = 16'd10000;   // mirror of the register
  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;
  int          hold_req = 0;             // bumped to ask for a long output stall
  int          hold_done = 0;
  int          words_sent = 0;
  int          quiet_cycles = 0;

  initial begin
    ref_ch.valid   = 1'b0;
    ref_ch.v_alpha = '0;
    ref_ch.v_beta  = '0;
    ref_ch.dc_link = '0;
    cmp_ch.ready   = 1'b0;
  end

  // --------------------------------------------------------------------------
  // output side: random back-pressure, long hold on request, checking
  // --------------------------------------------------------------------------
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && hold_done != hold_req) begin
        hold_done = hold_req;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        cmp_ch.ready <= 1'b0;
      end else begin
        cmp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && cmp_ch.valid && cmp_ch.ready)
      sb.check_compare({cmp_ch.compare_a, cmp_ch.compare_b, cmp_ch.compare_c,
                        cmp_ch.sector_number, cmp_ch.overmodulated, cmp_ch.dc_fault});
  end

  // watchdog: no word moving on either side for too long ends the run
  always @(posedge clk_i) begin
    if ((ref_ch.valid && ref_ch.ready) || (cmp_ch.valid && cmp_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("watchdog: nothing accepted for %0d cycles", WD_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------
  // offers one reference word, with a random gap first, and waits for accept
  task automatic send_ref(logic signed [15:0] va, logic signed [15:0] vb,
                          logic [15:0] vdc);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      ref_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    ref_ch.valid   <= 1'b1;
    ref_ch.v_alpha <= va;
    ref_ch.v_beta  <= vb;
    ref_ch.dc_link <= vdc;
    @(posedge clk_i);
    while (!ref_ch.ready) @(posedge clk_i);
    sb.note_reference(va, vb, vdc, period_now);
    words_sent++;
  endtask

  // random reference with weight on sector edges, small and huge vectors
  task automatic send_random_ref();
    logic signed [15:0] va, vb;
    logic [15:0] vdc;
    longint edge_b;
    va = 16'($urandom());
    vb = 16'($urandom());
    case ($urandom_range(9))
      0: begin
        va = 16'($signed($urandom_range(64)) - 32);
        vb = 16'($signed($urandom_range(64)) - 32);
      end
      1: vb = 0;
      2: va = 0;
      3: begin
        // on the line beta = +-sqrt3 * alpha, with a little jitter
        va = 16'($signed($urandom_range(37000)) - 18500);
        edge_b = (longint'(va) * SQRT3_Q16) >>> FRAC;
        if ($urandom_range(1)) edge_b = -edge_b;
        edge_b = edge_b + $signed($urandom_range(2)) - 1;
        vb = edge_b[15:0];
      end
      default: ;
    endcase
    case ($urandom_range(9))
      0:       vdc = 16'd0;
      1:       vdc = 16'hFFFF;
      2:       vdc = 16'($urandom_range(1, 64));
      3, 4:    vdc = 16'($urandom_range(1000, 8000));
      default: vdc = 16'($urandom());
    endcase
    send_ref(va, vb, vdc);
  endtask

  task automatic write_period(logic [15:0] tp);
    @(negedge clk_i);
    carrier_period_we_i <= 1'b1;
    carrier_period_i    <= tp;
    @(negedge clk_i);
    carrier_period_we_i <= 1'b0;
    period_now = tp;
  endtask

  // stop offering, then let every expected word come back
  task automatic drain();
    @(negedge clk_i);
    ref_ch.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [15:0] tp, int src_pct, int snk_pct, int n);
    write_period(tp);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    repeat (n) send_random_ref();
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    // directed words at the reset period, with idling on both sides
    src_idle_pct = 29;
    snk_idle_pct = 64;
    send_ref(16'sd0, 16'sd0, 16'd1000);         // zero vector
    send_ref(16'sd0, 16'sd0, 16'd0);            // dc fault on the zero vector
    send_ref(16'sd1000, 16'sd500, 16'd0);       // dc fault keeps the sector
    send_ref(16'sd32767, 16'sd0, 16'd65535);    // alpha axis
    send_ref(-16'sd32768, 16'sd0, 16'd65535);
    send_ref(16'sd0, 16'sd32767, 16'd65535);    // beta axis
    send_ref(16'sd0, -16'sd32768, 16'd65535);
    send_ref(16'sd32767, 16'sd32767, 16'd1);    // hard overmodulation
    send_ref(-16'sd32768, -16'sd32768, 16'd1);
    send_ref(16'sd1000, 16'sd1732, 16'd4000);   // near the edge between sector 1 and sector 2
    send_ref(-16'sd1000, 16'sd1732, 16'd4000);  // near the edge between sector 2 and sector 3
    send_ref(16'sd1000, -16'sd1732, 16'd4000);
    send_ref(16'sd400, 16'sd100, 16'd1000);     // sector 1
    send_ref(16'sd0, 16'sd400, 16'd1000);       // sector 2
    send_ref(-16'sd400, 16'sd100, 16'd1000);    // sector 3
    send_ref(-16'sd400, -16'sd100, 16'd1000);   // sector 4
    send_ref(16'sd0, -16'sd400, 16'd1000);      // sector 5
    send_ref(16'sd400, -16'sd100, 16'd1000);    // sector 6
    send_ref(16'sd577, 16'sd0, 16'd1000);       // about dc_link / sqrt3, still inside the overmodulation limit
    send_ref(16'sd578, 16'sd0, 16'd1000);
    send_ref(-16'sd1, 16'sd1, 16'd65535);       // tiny vector
    repeat (300) send_random_ref();
    drain();

    // largest period, with a long output stall while input keeps coming
    write_period(16'hFFFF);
    repeat (40) send_random_ref();
    hold_req++;
    repeat (310) send_random_ref();
    drain();

    run_phase(16'd2, 64, 29, 300);
    run_phase(16'd1, 64, 29, 60);
    run_phase(16'd0, 64, 29, 60);
    run_phase(16'($urandom_range(3, 40000)), 0, 0, 350);
    run_phase(16'd12345, 0, 0, 350);

    $display("sent %0d reference words over seven periods, checked %0d compare words",
             words_sent, sb.words_checked);
    $display("edge, overmodulation and dc fault cases mixed in; %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
